>>> rtl/vau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vau_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 3;
    localparam int MUL_SLOTS     = 6;
    localparam int PROD_W        = 64;
    localparam int RAD_W         = 64;
    localparam int ROOT_W        = 32;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_MUL   = 4'd2;
    localparam logic [3:0] CMD_DIV   = 4'd3;
    localparam logic [3:0] CMD_SCALE = 4'd4;
    localparam logic [3:0] CMD_SDIV  = 4'd5;
    localparam logic [3:0] CMD_DOT   = 4'd6;
    localparam logic [3:0] CMD_CROSS = 4'd7;
    localparam logic [3:0] CMD_LEN   = 4'd8;
    localparam logic [3:0] CMD_SQLEN = 4'd9;
    localparam logic [3:0] CMD_NORM  = 4'd10;

    typedef struct packed {
        logic [3:0]                   cmd;
        logic [LANES-1:0][DATA_W-1:0] a;
        logic [LANES-1:0][DATA_W-1:0] d;
        logic [LANES-1:0][DATA_W-1:0] r;
        logic [DATA_W-1:0]            so;
        logic                         ovf;
    } sq_side_t;

    typedef struct packed {
        logic [3:0]                   cmd;
        logic [LANES-1:0][DATA_W-1:0] r;
        logic [DATA_W-1:0]            so;
        logic                         ovf;
        logic                         dz;
        logic [LANES-1:0]             fixed;
        logic [LANES-1:0]             neg;
    } dv_side_t;

    // {saturated flag, value}
    function automatic logic [DATA_W:0] sat_s32(input logic signed [PROD_W-1:0] v);
        logic [DATA_W:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            res = {1'b1, S32_MAX};
        else if (v < 64'shFFFF_FFFF_8000_0000)
            res = {1'b1, S32_MIN};
        else
            res = {1'b0, v[DATA_W-1:0]};
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vau_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module vau_sqrt_pipe
    import vau_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_rad,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output logic [SIDE_W-1:0]      out_side
);

    logic [ROOT_W-1:0] valid_reg;
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [RAD_W-1:0]  root_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];

    logic [RAD_W-1:0]  rad_cur   [ROOT_W];
    logic [RAD_W-1:0]  root_cur  [ROOT_W];
    logic [RAD_W-1:0]  trial     [ROOT_W];
    logic [RAD_W-1:0]  rad_next  [ROOT_W];
    logic [RAD_W-1:0]  root_next [ROOT_W];

    always_comb
    begin
        rad_cur[0]  = in_rad;
        root_cur[0] = '0;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rad_cur[k]  = rad_reg[k-1];
            root_cur[k] = root_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            trial[k] = root_cur[k] + (RAD_W'(1) << (2 * (ROOT_W - 1 - k)));
            if (rad_cur[k] >= trial[k])
            begin
                rad_next[k]  = rad_cur[k] - trial[k];
                root_next[k] = (root_cur[k] >> 1) + (RAD_W'(1) << (2 * (ROOT_W - 1 - k)));
            end
            else
            begin
                rad_next[k]  = rad_cur[k];
                root_next[k] = root_cur[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[ROOT_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < ROOT_W; k++)
                side_reg[k] <= side_reg[k-1];
            for (int k = 0; k < ROOT_W; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/vau_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module vau_div_pipe
    import vau_pkg::*;
#(
    parameter int NUM_W  = 48,
    parameter int SIDE_W = 1
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic [LANES-1:0][NUM_W-1:0]  in_num,
    input  wire logic [LANES-1:0][DATA_W-1:0] in_den,
    input  wire logic [SIDE_W-1:0]            in_side,
    output logic                              out_valid,
    output logic [LANES-1:0][NUM_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]                 out_side
);

    logic [NUM_W-1:0]  valid_reg;
    logic [DATA_W-1:0] rem_reg  [NUM_W][LANES];
    logic [NUM_W-1:0]  nq_reg   [NUM_W][LANES];
    logic [DATA_W-1:0] den_reg  [NUM_W][LANES];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    logic [DATA_W-1:0] rem_cur  [NUM_W][LANES];
    logic [NUM_W-1:0]  nq_cur   [NUM_W][LANES];
    logic [DATA_W-1:0] den_cur  [NUM_W][LANES];
    logic [DATA_W:0]   part     [NUM_W][LANES];
    logic              ge       [NUM_W][LANES];
    logic [DATA_W-1:0] rem_next [NUM_W][LANES];
    logic [NUM_W-1:0]  nq_next  [NUM_W][LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_cur[0][l] = '0;
            nq_cur[0][l]  = in_num[l];
            den_cur[0][l] = in_den[l];
            for (int k = 1; k < NUM_W; k++)
            begin
                rem_cur[k][l] = rem_reg[k-1][l];
                nq_cur[k][l]  = nq_reg[k-1][l];
                den_cur[k][l] = den_reg[k-1][l];
            end
            for (int k = 0; k < NUM_W; k++)
            begin
                part[k][l] = {rem_cur[k][l], nq_cur[k][l][NUM_W-1]};
                ge[k][l]   = part[k][l] >= {1'b0, den_cur[k][l]};
                if (ge[k][l])
                    rem_next[k][l] = DATA_W'(part[k][l] - {1'b0, den_cur[k][l]});
                else
                    rem_next[k][l] = part[k][l][DATA_W-1:0];
                nq_next[k][l] = {nq_cur[k][l][NUM_W-2:0], ge[k][l]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NUM_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < NUM_W; k++)
                side_reg[k] <= side_reg[k-1];
            for (int k = 0; k < NUM_W; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    nq_reg[k][l]  <= nq_next[k][l];
                    den_reg[k][l] <= den_cur[k][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            out_quo[l] = nq_reg[NUM_W-1][l];
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/vector3d_arithmetic_unit.sv
// Data are signed fixed point, Q16.16 at the default FRAC_BITS.
// Throughput: one item per cycle; the whole pipeline advances together unless
// the output register holds an item that is stalled.
// Depth is set by the 32-step square root pipe followed by the
// (32 + FRAC_BITS)-step divider pipe. Reset clears all valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module vector3d_arithmetic_unit
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [3:0]         cmd,
    input  wire logic [DATA_W-1:0]  ax,
    input  wire logic [DATA_W-1:0]  ay,
    input  wire logic [DATA_W-1:0]  az,
    input  wire logic [DATA_W-1:0]  bx,
    input  wire logic [DATA_W-1:0]  by_comp,
    input  wire logic [DATA_W-1:0]  bz,
    input  wire logic [DATA_W-1:0]  scalar_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DATA_W-1:0]       rx,
    output logic [DATA_W-1:0]       ry,
    output logic [DATA_W-1:0]       rz,
    output logic [DATA_W-1:0]       scalar_out,
    output logic                    div_zero,
    output logic                    overflow
);

    localparam int NUM_W = DATA_W + FRAC_BITS;

    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // input register
    logic                         s1_valid_reg;
    logic [3:0]                   s1_cmd_reg;
    logic [LANES-1:0][DATA_W-1:0] s1_a_reg;
    logic [LANES-1:0][DATA_W-1:0] s1_b_reg;
    logic [DATA_W-1:0]            s1_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= cmd;
            s1_a_reg   <= {az, ay, ax};
            s1_b_reg   <= {bz, by_comp, bx};
            s1_s_reg   <= scalar_in;
        end
    end

    // multiply
    logic signed [DATA_W-1:0] mx [MUL_SLOTS];
    logic signed [DATA_W-1:0] my [MUL_SLOTS];

    always_comb
    begin
        for (int k = 0; k < MUL_SLOTS; k++)
        begin
            mx[k] = '0;
            my[k] = '0;
        end
        unique case (s1_cmd_reg)
            CMD_CROSS:
            begin
                mx[0] = s1_a_reg[1]; my[0] = s1_b_reg[2];
                mx[1] = s1_a_reg[2]; my[1] = s1_b_reg[1];
                mx[2] = s1_a_reg[2]; my[2] = s1_b_reg[0];
                mx[3] = s1_a_reg[0]; my[3] = s1_b_reg[2];
                mx[4] = s1_a_reg[0]; my[4] = s1_b_reg[1];
                mx[5] = s1_a_reg[1]; my[5] = s1_b_reg[0];
            end
            CMD_SCALE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mx[i] = s1_a_reg[i];
                    my[i] = s1_s_reg;
                end
            end
            CMD_LEN, CMD_SQLEN, CMD_NORM:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mx[i] = s1_a_reg[i];
                    my[i] = s1_a_reg[i];
                end
            end
            default:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mx[i] = s1_a_reg[i];
                    my[i] = s1_b_reg[i];
                end
            end
        endcase
    end

    logic                         s2_valid_reg;
    logic [3:0]                   s2_cmd_reg;
    logic [LANES-1:0][DATA_W-1:0] s2_a_reg;
    logic [LANES-1:0][DATA_W-1:0] s2_b_reg;
    logic [DATA_W-1:0]            s2_s_reg;
    logic signed [PROD_W-1:0]     s2_prod_reg [MUL_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_a_reg   <= s1_a_reg;
            s2_b_reg   <= s1_b_reg;
            s2_s_reg   <= s1_s_reg;
            for (int k = 0; k < MUL_SLOTS; k++)
                s2_prod_reg[k] <= PROD_W'(mx[k]) * PROD_W'(my[k]);
        end
    end

    // combine products, add and subtract
    logic signed [PROD_W-1:0] fs [MUL_SLOTS];
    logic [RAD_W-1:0]         sq_sum;
    logic [RAD_W-1:0]         sqlen_v;
    logic [DATA_W:0]          sat_v [LANES];
    logic [DATA_W:0]          sat_s;
    logic                     vec_en;
    logic                     sc_en;
    sq_side_t                 s3_side_next;

    always_comb
    begin
        for (int k = 0; k < MUL_SLOTS; k++)
            fs[k] = s2_prod_reg[k] >>> FRAC_BITS;
        sq_sum  = RAD_W'(s2_prod_reg[0]) + RAD_W'(s2_prod_reg[1]) + RAD_W'(s2_prod_reg[2]);
        sqlen_v = sq_sum >> FRAC_BITS;
        for (int i = 0; i < LANES; i++)
            sat_v[i] = '0;
        sat_s  = '0;
        vec_en = 1'b0;
        sc_en  = 1'b0;
        s3_side_next.cmd = s2_cmd_reg;
        s3_side_next.a   = s2_a_reg;
        s3_side_next.d   = '0;
        s3_side_next.r   = '0;
        s3_side_next.so  = '0;
        s3_side_next.ovf = 1'b0;
        unique case (s2_cmd_reg)
            CMD_ADD:
            begin
                vec_en = 1'b1;
                for (int i = 0; i < LANES; i++)
                    sat_v[i] = sat_s32(PROD_W'($signed(s2_a_reg[i]))
                                       + PROD_W'($signed(s2_b_reg[i])));
            end
            CMD_SUB:
            begin
                vec_en = 1'b1;
                for (int i = 0; i < LANES; i++)
                    sat_v[i] = sat_s32(PROD_W'($signed(s2_a_reg[i]))
                                       - PROD_W'($signed(s2_b_reg[i])));
            end
            CMD_MUL, CMD_SCALE:
            begin
                vec_en = 1'b1;
                for (int i = 0; i < LANES; i++)
                    sat_v[i] = sat_s32(fs[i]);
            end
            CMD_DIV:
            begin
                s3_side_next.d = s2_b_reg;
            end
            CMD_SDIV:
            begin
                for (int i = 0; i < LANES; i++)
                    s3_side_next.d[i] = s2_s_reg;
            end
            CMD_DOT:
            begin
                sc_en = 1'b1;
                sat_s = sat_s32(fs[0] + fs[1] + fs[2]);
            end
            CMD_CROSS:
            begin
                vec_en   = 1'b1;
                sat_v[0] = sat_s32(fs[0] - fs[1]);
                sat_v[1] = sat_s32(fs[2] - fs[3]);
                sat_v[2] = sat_s32(fs[4] - fs[5]);
            end
            CMD_SQLEN:
            begin
                sc_en = 1'b1;
                if (sqlen_v > RAD_W'(S32_MAX))
                    sat_s = {1'b1, S32_MAX};
                else
                    sat_s = {1'b0, sqlen_v[DATA_W-1:0]};
            end
            default:
            begin
                vec_en = 1'b0;
            end
        endcase
        if (vec_en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                s3_side_next.r[i] = sat_v[i][DATA_W-1:0];
                s3_side_next.ovf  = s3_side_next.ovf | sat_v[i][DATA_W];
            end
        end
        if (sc_en)
        begin
            s3_side_next.so  = sat_s[DATA_W-1:0];
            s3_side_next.ovf = sat_s[DATA_W];
        end
    end

    logic             s3_valid_reg;
    sq_side_t         s3_side_reg;
    logic [RAD_W-1:0] s3_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= s3_side_next;
            s3_sq_reg   <= sq_sum;
        end
    end

    // square root of the sum of squares
    logic                     sr_valid;
    logic [ROOT_W-1:0]        sr_root;
    logic [$bits(sq_side_t)-1:0] sr_side_raw;
    sq_side_t                 sr_side;

    vau_sqrt_pipe #(
        .SIDE_W ($bits(sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_sq_reg),
        .in_side   (s3_side_reg),
        .out_valid (sr_valid),
        .out_root  (sr_root),
        .out_side  (sr_side_raw)
    );

    assign sr_side = sq_side_t'(sr_side_raw);

    // divider setup
    dv_side_t                     st_side_next;
    logic [LANES-1:0][NUM_W-1:0]  st_num_next;
    logic [LANES-1:0][DATA_W-1:0] st_den_next;
    logic [DATA_W-1:0]            a_mag [LANES];
    logic [DATA_W-1:0]            d_mag [LANES];

    always_comb
    begin
        st_side_next.cmd   = sr_side.cmd;
        st_side_next.r     = sr_side.r;
        st_side_next.so    = sr_side.so;
        st_side_next.ovf   = sr_side.ovf;
        st_side_next.dz    = 1'b0;
        st_side_next.fixed = '0;
        st_side_next.neg   = '0;
        st_num_next        = '0;
        st_den_next        = '0;
        for (int i = 0; i < LANES; i++)
        begin
            a_mag[i] = sr_side.a[i][DATA_W-1] ? DATA_W'(0) - sr_side.a[i] : sr_side.a[i];
            d_mag[i] = sr_side.d[i][DATA_W-1] ? DATA_W'(0) - sr_side.d[i] : sr_side.d[i];
        end
        unique case (sr_side.cmd)
            CMD_LEN:
            begin
                if (sr_root[ROOT_W-1])
                begin
                    st_side_next.so  = S32_MAX;
                    st_side_next.ovf = 1'b1;
                end
                else
                begin
                    st_side_next.so = sr_root;
                end
            end
            CMD_DIV, CMD_SDIV:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    st_num_next[i]      = {a_mag[i], {FRAC_BITS{1'b0}}};
                    st_den_next[i]      = d_mag[i];
                    st_side_next.neg[i] = sr_side.a[i][DATA_W-1] ^ sr_side.d[i][DATA_W-1];
                    if (sr_side.d[i] == '0)
                    begin
                        st_side_next.fixed[i] = 1'b1;
                        st_side_next.dz       = 1'b1;
                        if (sr_side.a[i][DATA_W-1])
                            st_side_next.r[i] = S32_MIN;
                        else if (sr_side.a[i] != '0)
                            st_side_next.r[i] = S32_MAX;
                        else
                            st_side_next.r[i] = '0;
                    end
                end
            end
            CMD_NORM:
            begin
                if (sr_root == '0)
                begin
                    st_side_next.fixed = '1;
                    st_side_next.r[0]  = DATA_W'(1) << FRAC_BITS;
                    st_side_next.r[1]  = '0;
                    st_side_next.r[2]  = '0;
                end
                else
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        st_num_next[i]      = {a_mag[i], {FRAC_BITS{1'b0}}};
                        st_den_next[i]      = sr_root;
                        st_side_next.neg[i] = sr_side.a[i][DATA_W-1];
                    end
                end
            end
            default:
            begin
                st_side_next.dz = 1'b0;
            end
        endcase
    end

    logic                         st_valid_reg;
    dv_side_t                     st_side_reg;
    logic [LANES-1:0][NUM_W-1:0]  st_num_reg;
    logic [LANES-1:0][DATA_W-1:0] st_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (adv)
            st_valid_reg <= sr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_side_reg <= st_side_next;
            st_num_reg  <= st_num_next;
            st_den_reg  <= st_den_next;
        end
    end

    // divide
    logic                        dv_valid;
    logic [LANES-1:0][NUM_W-1:0] dv_quo;
    logic [$bits(dv_side_t)-1:0] dv_side_raw;
    dv_side_t                    dv_side;

    vau_div_pipe #(
        .NUM_W  (NUM_W),
        .SIDE_W ($bits(dv_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (st_valid_reg),
        .in_num    (st_num_reg),
        .in_den    (st_den_reg),
        .in_side   (st_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side_raw)
    );

    assign dv_side = dv_side_t'(dv_side_raw);

    // sign, saturate and register the result
    logic [DATA_W-1:0] res_r [LANES];
    logic              res_ovf;
    logic              is_div;

    always_comb
    begin
        is_div  = (dv_side.cmd == CMD_DIV) || (dv_side.cmd == CMD_SDIV)
                  || (dv_side.cmd == CMD_NORM);
        res_ovf = dv_side.ovf;
        for (int i = 0; i < LANES; i++)
        begin
            res_r[i] = dv_side.r[i];
            if (is_div && !dv_side.fixed[i])
            begin
                if (!dv_side.neg[i])
                begin
                    if (dv_quo[i] > NUM_W'(S32_MAX))
                    begin
                        res_r[i] = S32_MAX;
                        res_ovf  = 1'b1;
                    end
                    else
                    begin
                        res_r[i] = dv_quo[i][DATA_W-1:0];
                    end
                end
                else
                begin
                    if (dv_quo[i] > NUM_W'(S32_MIN))
                    begin
                        res_r[i] = S32_MIN;
                        res_ovf  = 1'b1;
                    end
                    else
                    begin
                        res_r[i] = DATA_W'(0) - dv_quo[i][DATA_W-1:0];
                    end
                end
            end
        end
    end

    logic [DATA_W-1:0] rx_reg;
    logic [DATA_W-1:0] ry_reg;
    logic [DATA_W-1:0] rz_reg;
    logic [DATA_W-1:0] so_reg;
    logic              dz_reg;
    logic              ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg  <= res_r[0];
            ry_reg  <= res_r[1];
            rz_reg  <= res_r[2];
            so_reg  <= dv_side.so;
            dz_reg  <= dv_side.dz;
            ovf_reg <= res_ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rx         = rx_reg;
    assign ry         = ry_reg;
    assign rz         = rz_reg;
    assign scalar_out = so_reg;
    assign div_zero   = dz_reg;
    assign overflow   = ovf_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import vau_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 69 + FB;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] so;
        logic dz;
        logic ovf;
    } vec_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [3:0] cmd = '0;
    logic [31:0] ax = '0, ay = '0, az = '0, bx = '0, by_comp = '0, bz = '0, scalar_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] rx, ry, rz, scalar_out;
    logic div_zero, overflow;

    vec_result_t expected_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    bit hold_off = 0;
    int hold_cycles = 0;
    int rx_gap = 0;
    bit rx_idle_en = 1;
    bit tx_idle_en = 1;

    vector3d_arithmetic_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic longint sat(input longint v, inout bit ovf);
        if (v > SMAX)
        begin
            ovf = 1;
            return SMAX;
        end
        if (v < SMIN)
        begin
            ovf = 1;
            return SMIN;
        end
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> FB;
    endfunction

    function automatic longint fx_div(input longint a, input longint b, inout bit dz,
                                      inout bit ovf);
        if (b == 0)
        begin
            dz = 1;
            return (a > 0) ? SMAX : ((a < 0) ? SMIN : 0);
        end
        return sat((a <<< FB) / b, ovf);
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic vec_result_t vector_op(input logic [3:0] op,
                                              input logic [31:0] av[3],
                                              input logic [31:0] bv[3],
                                              input logic [31:0] sv);
        longint a[3], b[3], s, r[3], so, len;
        longint unsigned sq, u;
        bit dz, ovf;
        vec_result_t res;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'($signed(av[i]));
            b[i] = longint'($signed(bv[i]));
            r[i] = 0;
        end
        s = longint'($signed(sv));
        so = 0;
        dz = 0;
        ovf = 0;
        sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        case (op)
            CMD_ADD:
                for (int i = 0; i < 3; i++) r[i] = sat(a[i] + b[i], ovf);
            CMD_SUB:
                for (int i = 0; i < 3; i++) r[i] = sat(a[i] - b[i], ovf);
            CMD_MUL:
                for (int i = 0; i < 3; i++) r[i] = sat(fx_mul(a[i], b[i]), ovf);
            CMD_DIV:
                for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], b[i], dz, ovf);
            CMD_SCALE:
                for (int i = 0; i < 3; i++) r[i] = sat(fx_mul(a[i], s), ovf);
            CMD_SDIV:
                for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], s, dz, ovf);
            CMD_DOT:
                so = sat(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]), ovf);
            CMD_CROSS:
            begin
                r[0] = sat(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]), ovf);
                r[1] = sat(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]), ovf);
                r[2] = sat(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]), ovf);
            end
            CMD_LEN:
            begin
                u = root64(sq);
                if (u > 64'd2147483647)
                begin
                    ovf = 1;
                    so = SMAX;
                end
                else
                    so = longint'(u);
            end
            CMD_SQLEN:
            begin
                u = sq >> FB;
                if (u > 64'd2147483647)
                begin
                    ovf = 1;
                    so = SMAX;
                end
                else
                    so = longint'(u);
            end
            CMD_NORM:
                if (sq == 0)
                    r[0] = 64'sd1 <<< FB;
                else
                begin
                    len = longint'(root64(sq));
                    for (int i = 0; i < 3; i++) r[i] = sat((a[i] <<< FB) / len, ovf);
                end
            default: ;
        endcase
        res.rx = r[0][31:0];
        res.ry = r[1][31:0];
        res.rz = r[2][31:0];
        res.so = so[31:0];
        res.dz = dz;
        res.ovf = ovf;
        return res;
    endfunction

    // valid stays high after an item so that the next one can follow directly;
    // drop it before any idle stretch
    task automatic send_item(input logic [3:0] op, input logic [31:0] av[3],
                             input logic [31:0] bv[3], input logic [31:0] sv);
        int g;
        g = tx_idle_en ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        cmd <= op;
        ax <= av[0];
        ay <= av[1];
        az <= av[2];
        bx <= bv[0];
        by_comp <= bv[1];
        bz <= bv[2];
        scalar_in <= sv;
        in_valid <= 1'b1;
        expected_q.push_back(vector_op(op, av, bv, sv));
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
            4: return 32'(int'($urandom_range(0, 2000 << FB)) - (1000 << FB));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random(input logic [3:0] op);
        logic [31:0] av[3], bv[3], sv;
        for (int i = 0; i < 3; i++)
        begin
            av[i] = rand_word();
            bv[i] = rand_word();
        end
        sv = rand_word();
        send_item(op, av, bv, sv);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        logic [31:0] mx[3], mn[3], zr[3], one[3];
        for (int i = 0; i < 3; i++)
        begin
            mx[i] = 32'h7FFF_FFFF;
            mn[i] = 32'h8000_0000;
            zr[i] = 32'h0;
            one[i] = 32'h0001_0000;
        end
        for (int op = 0; op < 16; op++)
            send_item(4'(op), mx, mn, 32'h8000_0000);
        send_item(CMD_ADD, mx, mx, 0);
        send_item(CMD_SUB, mn, mx, 0);
        send_item(CMD_DIV, one, zr, 0);
        send_item(CMD_DIV, mn, zr, 0);
        send_item(CMD_DIV, zr, zr, 0);
        send_item(CMD_SDIV, mx, one, 32'h0);
        send_item(CMD_NORM, zr, one, 0);
        send_item(CMD_LEN, mn, zr, 0);
        send_item(CMD_NORM, one, zr, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_ops(input int n);
        for (int k = 0; k < n; k++)
            send_random(4'($urandom_range(0, 99) < 95 ? $urandom_range(0, 10)
                                                         : $urandom_range(11, 15)));
    endtask

    task automatic test_backpressure();
        hold_cycles = 2 * LATENCY + 40;
        hold_off = 1;
        tx_idle_en = 0;
        test_random_ops(LATENCY + 60);
        tx_idle_en = 1;
    endtask

    task automatic test_pause_drain();
        test_random_ops(40);
        wait_drained();
        test_random_ops(40);
    endtask

    task automatic test_no_idling();
        tx_idle_en = 0;
        rx_idle_en = 0;
        test_random_ops(120);
        tx_idle_en = 1;
        rx_idle_en = 1;
    endtask

    always @(negedge clk)
    begin
        if (hold_off)
        begin
            out_stall <= 1'b1;
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            else
                hold_off <= 0;
        end
        else if (rx_gap > 0)
        begin
            out_stall <= 1'b1;
            rx_gap <= rx_gap - 1;
        end
        else if (rx_idle_en && ($urandom_range(0, 3) == 0))
        begin
            out_stall <= 1'b1;
            rx_gap <= gap_len();
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        vec_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result rx=%h ry=%h rz=%h so=%h", rx, ry, rz,
                             scalar_out);
            end
            else
            begin
                e = expected_q.pop_front();
                if (rx !== e.rx || ry !== e.ry || rz !== e.rz || scalar_out !== e.so
                    || div_zero !== e.dz || overflow !== e.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h so=%h dz=%b ovf=%b got %h %h %h so=%h dz=%b ovf=%b",
                                 e.rx, e.ry, e.rz, e.so, e.dz, e.ovf,
                                 rx, ry, rz, scalar_out, div_zero, overflow);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        int spin;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_random_ops(150);
        test_backpressure();
        test_pause_drain();
        test_no_idling();
        test_random_ops(150);
        in_valid <= 1'b0;
        spin = 0;
        while (expected_q.size() != 0 && spin < 20000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (LATENCY + 20) @(posedge clk);
        $display("Sent %0d items over all opcodes, extremes and divide by zero;", items_sent);
        $display("checked %0d results under random and long output stalls.", results_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
